[rtl/rendezvous_bin_select_core_defines.svh]
// Assertion macros used by the top-level core to check its own logic.
`ifndef RENDEZVOUS_BIN_SELECT_CORE_DEFINES_SVH
`define RENDEZVOUS_BIN_SELECT_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rbs_pkg.sv]
package rbs_pkg;

  localparam int MUL_STEPS = 7;

  typedef logic [2:0] step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  load;
    logic  init;
    logic  rd_en;
    logic  mul_en;
    logic  cmp_en;
    step_t step;
  } rbs_cmd_t;

  typedef struct packed {
    logic last_node;
  } rbs_status_t;

  // Each step multiplies one 32-bit seed limb by one 32-bit key limb. Only the
  // partial products that reach below bit 128 are formed.
  function automatic logic [1:0] step_seed_limb(step_t step);
    logic [1:0] limb;
    case (step)
      3'd0: limb = 2'd0;
      3'd1: limb = 2'd0;
      3'd2: limb = 2'd1;
      3'd3: limb = 2'd1;
      3'd4: limb = 2'd2;
      3'd5: limb = 2'd2;
      3'd6: limb = 2'd3;
      default: limb = 2'd0;
    endcase
    return limb;
  endfunction

  function automatic logic step_key_limb(step_t step);
    logic limb;
    case (step)
      3'd1: limb = 1'b1;
      3'd3: limb = 1'b1;
      3'd5: limb = 1'b1;
      default: limb = 1'b0;
    endcase
    return limb;
  endfunction

  // The product is shifted left by this code times 32 bits.
  function automatic logic [1:0] step_shift(step_t step);
    return step_seed_limb(step) + {1'b0, step_key_limb(step)};
  endfunction

endpackage

[rtl/rbs_ram.sv]
module rbs_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/rbs_ctrl.sv]
module rbs_ctrl
  import rbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        mode,
  input  rbs_status_t status,
  output rbs_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (start && mode) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_MUL;
        step_nxt  = '0;
      end
      ST_MUL: begin
        step_nxt = step_r + 3'd1;
        if (step_r == step_t'(MUL_STEPS - 1)) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = status.last_node ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.step = step_r;
    busy     = 1'b1;
    done     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start && !mode;
        cmd.init = start && mode;
      end
      ST_READ: cmd.rd_en  = 1'b1;
      ST_MUL:  cmd.mul_en = 1'b1;
      ST_ACC:  cmd.mul_en = 1'b0;
      ST_CMP:  cmd.cmp_en = 1'b1;
      ST_DONE: done       = 1'b1;
      default: busy       = 1'b1;
    endcase
  end

endmodule

[rtl/rbs_datapath.sv]
module rbs_datapath
  import rbs_pkg::*;
#(
  parameter int NODE_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  rbs_cmd_t    cmd,
  input  logic [3:0]  node,
  input  logic [63:0] seed_high,
  input  logic [63:0] seed_low,
  input  logic [63:0] key,
  output rbs_status_t status,
  output logic [3:0]  bin
);

  localparam int IW = $clog2(NODE_COUNT);

  logic [NODE_COUNT-1:0] valid_r, valid_nxt;
  logic [IW-1:0]         node_cnt_r, node_cnt_nxt;
  logic                  prod_valid_r;
  logic                  rd_valid_r;
  logic [63:0]           key_r;
  logic [63:0]           prod_r;
  logic [1:0]            shift_r;
  logic [127:0]          acc_r;
  logic [127:0]          best_r;
  logic [IW-1:0]         best_idx_r;

  logic                  node_ok;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [127:0]          rd_data;
  logic [127:0]          seed;
  logic [31:0]           seed_limb;
  logic [31:0]           key_limb;
  logic [127:0]          prod_shifted;

  assign node_ok = 32'(node) < NODE_COUNT;
  assign wr_en   = cmd.load && node_ok;
  assign wr_addr = IW'(node);

  rbs_ram #(
    .WIDTH(128),
    .DEPTH(NODE_COUNT)
  ) u_seed_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data({seed_high, seed_low}),
    .rd_en  (cmd.rd_en),
    .rd_addr(node_cnt_r),
    .rd_data(rd_data)
  );

  // A node that was never loaded reads as an all-zero seed.
  assign seed = rd_valid_r ? rd_data : '0;

  always_comb begin
    case (step_seed_limb(cmd.step))
      2'd0:    seed_limb = seed[31:0];
      2'd1:    seed_limb = seed[63:32];
      2'd2:    seed_limb = seed[95:64];
      2'd3:    seed_limb = seed[127:96];
      default: seed_limb = seed[31:0];
    endcase
  end

  assign key_limb     = step_key_limb(cmd.step) ? key_r[63:32] : key_r[31:0];
  assign prod_shifted = 128'(prod_r) << {shift_r, 5'b0};

  always_comb begin
    valid_nxt    = valid_r;
    node_cnt_nxt = node_cnt_r;
    if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
    if (cmd.init) begin
      node_cnt_nxt = '0;
    end else if (cmd.cmp_en) begin
      node_cnt_nxt = node_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      node_cnt_r   <= '0;
      prod_valid_r <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      node_cnt_r   <= node_cnt_nxt;
      prod_valid_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      key_r      <= ~key;
      best_r     <= '0;
      best_idx_r <= '0;
    end
    if (cmd.rd_en) begin
      rd_valid_r <= valid_r[node_cnt_r];
      acc_r      <= '0;
    end else if (prod_valid_r) begin
      acc_r <= acc_r + prod_shifted;
    end
    if (cmd.mul_en) begin
      prod_r  <= 64'(seed_limb) * 64'(key_limb);
      shift_r <= step_shift(cmd.step);
    end
    if (cmd.cmp_en && (acc_r >= best_r)) begin
      best_r     <= acc_r;
      best_idx_r <= node_cnt_r;
    end
  end

  assign status.last_node = node_cnt_r == IW'(NODE_COUNT - 1);
  assign bin              = 4'(best_idx_r);

endmodule

[rtl/rendezvous_bin_select_core.sv]
// Channel   Handshake          Ports
// request   start / busy       in_mode, in_node, in_seed_high, in_seed_low, in_key
// result    out_valid strobe   out_bin
//
// A load request is written to the seed RAM at acceptance.
// A lookup keeps the block busy from the accepting edge to the result, and the next
// request can be accepted once the block is back in idle:
// each node costs one RAM read, seven 32x32 partial products through the single
// shared multiplier, one final accumulate and one compare.
// Reset clears the seed valid bits, so every seed reads as zero until loaded.
// The result is shown for one cycle and cannot be stalled.
`include "rendezvous_bin_select_core_defines.svh"

module rendezvous_bin_select_core
  import rbs_pkg::*;
#(
  parameter int NODE_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [3:0]  in_node,
  input  logic [63:0] in_seed_high,
  input  logic [63:0] in_seed_low,
  input  logic [63:0] in_key,
  output logic        out_valid,
  output logic [3:0]  out_bin
);

  rbs_cmd_t    cmd;
  rbs_status_t status;

  rbs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_mode),
    .status(status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  rbs_datapath #(
    .NODE_COUNT(NODE_COUNT)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .node     (in_node),
    .seed_high(in_seed_high),
    .seed_low (in_seed_low),
    .key      (in_key),
    .status   (status),
    .bin      (out_bin)
  );

  `RBS_ASSERT_SAME(a_result_while_busy, out_valid, busy, "result outside a lookup")
  `RBS_ASSERT_NEXT(a_result_single, out_valid, !out_valid, "result strobe repeated")
  `RBS_ASSERT_NEXT(a_lookup_starts, start && !busy && in_mode, busy, "lookup not started")
  `RBS_ASSERT_NEXT(a_load_silent, start && !busy && !in_mode, !busy && !out_valid,
                   "load request left the block busy")

endmodule

[tb/rbs_bin_checker.sv]
module rbs_bin_checker #(
  parameter int NODE_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_mode,
  input  logic [3:0]  in_node,
  input  logic [63:0] in_seed_high,
  input  logic [63:0] in_seed_low,
  input  logic [63:0] in_key,
  input  logic        out_valid,
  input  logic [3:0]  out_bin,
  output int          open_count,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_LOOKUP = 1'b1;

  logic [127:0] node_seed [NODE_COUNT];
  logic [3:0]   bins_due [$];
  int           mismatches = 0;

  // Weights wrap modulo 2^128, and the later node wins a tie.
  function automatic logic [3:0] heaviest_node(logic [63:0] key);
    logic [127:0] factor;
    logic [127:0] weight;
    logic [127:0] top_weight;
    int           best;
    int           n;
    factor = {64'd0, ~key};
    top_weight = '0;
    best = 0;
    for (n = 0; n < NODE_COUNT; n++) begin
      weight = node_seed[n] * factor;
      if (weight >= top_weight) begin
        top_weight = weight;
        best = n;
      end
    end
    return best[3:0];
  endfunction

  always @(posedge clk) begin
    logic [3:0] due;
    if (!rst_n) begin
      for (int n = 0; n < NODE_COUNT; n++) begin
        node_seed[n] = '0;
      end
      bins_due.delete();
    end else begin
      if (out_valid) begin
        if (bins_due.size() == 0) begin
          $error("out_bin: no result expected, actual %0d", out_bin);
          mismatches++;
        end else begin
          due = bins_due.pop_front();
          if (out_bin !== due) begin
            $error("out_bin: expected %0d, actual %0d", due, out_bin);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        if (in_mode == MODE_LOOKUP) begin
          bins_due.push_back(heaviest_node(in_key));
        end else if (in_node < NODE_COUNT) begin
          node_seed[in_node] = {in_seed_high, in_seed_low};
        end
      end
    end
    open_count <= bins_due.size();
    fail_count <= mismatches;
  end

endmodule

[tb/rendezvous_bin_select_core_test.sv]
module rendezvous_bin_select_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   NODE_COUNT    = 16;
  localparam int   ITEM_TOTAL    = 1850;
  localparam int   CALM_TAIL     = 150;
  localparam int   SETTLE_CYCLES = 10 * NODE_COUNT + 40;
  localparam logic MODE_LOAD     = 1'b0;
  localparam logic MODE_LOOKUP   = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_mode;
  logic [3:0]  in_node;
  logic [63:0] in_seed_high;
  logic [63:0] in_seed_low;
  logic [63:0] in_key;
  logic        out_valid;
  logic [3:0]  out_bin;
  int          open_count;
  int          fail_count;

  int           issued = 0;
  bit           quiet = 1'b0;
  logic [127:0] twin_seed [4];

  always #5 clk = ~clk;

  rendezvous_bin_select_core #(
    .NODE_COUNT(NODE_COUNT)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_mode     (in_mode),
    .in_node     (in_node),
    .in_seed_high(in_seed_high),
    .in_seed_low (in_seed_low),
    .in_key      (in_key),
    .out_valid   (out_valid),
    .out_bin     (out_bin)
  );

  rbs_bin_checker #(
    .NODE_COUNT(NODE_COUNT)
  ) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_mode     (in_mode),
    .in_node     (in_node),
    .in_seed_high(in_seed_high),
    .in_seed_low (in_seed_low),
    .in_key      (in_key),
    .out_valid   (out_valid),
    .out_bin     (out_bin),
    .open_count  (open_count),
    .fail_count  (fail_count)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [127:0] seed_flavor();
    logic [127:0] seed;
    case ($urandom_range(0, 9))
      0: seed = '0;
      1: seed = '1;
      2: seed = {64'd0, rand64()};
      3: seed = {rand64(), 64'd0};
      4, 5: seed = twin_seed[$urandom_range(0, 3)];
      6: seed = 128'd1 << $urandom_range(0, 127);
      default: seed = {rand64(), rand64()};
    endcase
    return seed;
  endfunction

  function automatic logic [63:0] key_flavor();
    logic [63:0] key;
    case ($urandom_range(0, 9))
      0: key = '0;
      1: key = '1;
      2: key = 64'($urandom_range(0, 255));
      3: key = ~64'($urandom_range(0, 255));
      4: key = 64'd1 << $urandom_range(0, 63);
      default: key = rand64();
    endcase
    return key;
  endfunction

  // While start is low the request fields carry noise that must be ignored.
  task automatic maybe_pause();
    if (!quiet && issued < ITEM_TOTAL - CALM_TAIL && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      in_mode <= 1'($urandom_range(0, 1));
      in_node <= 4'($urandom_range(0, 15));
      in_seed_high <= rand64();
      in_seed_low <= rand64();
      in_key <= rand64();
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic issue(input logic mode, input logic [3:0] node,
                       input logic [127:0] seed, input logic [63:0] key);
    maybe_pause();
    start <= 1'b1;
    in_mode <= mode;
    in_node <= node;
    in_seed_high <= seed[127:64];
    in_seed_low <= seed[63:0];
    in_key <= key;
    do @(posedge clk); while (busy);
    issued++;
  endtask

  task automatic load_seed(input logic [3:0] node, input logic [127:0] seed);
    issue(MODE_LOAD, node, seed, rand64());
  endtask

  task automatic lookup_key(input logic [63:0] key);
    issue(MODE_LOOKUP, 4'($urandom_range(0, 15)), {rand64(), rand64()}, key);
  endtask

  initial begin
    #15ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [127:0] shared;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= MODE_LOAD;
    in_node <= '0;
    in_seed_high <= '0;
    in_seed_low <= '0;
    in_key <= '0;
    for (int i = 0; i < 4; i++) begin
      twin_seed[i] = {rand64(), rand64()};
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // With every seed still zero, all weights tie and the last node wins.
    lookup_key('0);
    lookup_key('1);
    load_seed(4'd0, '1);
    lookup_key('0);
    lookup_key(64'd1);
    load_seed(4'd7, {64'd0, 64'hFFFF_FFFF_FFFF_FFFF});
    load_seed(4'd3, {64'hFFFF_FFFF_FFFF_FFFF, 64'd0});
    lookup_key('1);
    lookup_key(64'h8000_0000_0000_0000);
    lookup_key(64'h7FFF_FFFF_FFFF_FFFF);
    load_seed(4'd0, '0);
    load_seed(4'd3, '0);
    load_seed(4'd7, '0);
    shared = {rand64(), rand64()};
    load_seed(4'd4, shared);
    load_seed(4'd11, shared);
    lookup_key(rand64());
    load_seed(4'd15, shared);
    lookup_key(rand64());
    load_seed(4'd15, '0);
    load_seed(4'd0, 128'd1);
    lookup_key('0);
    load_seed(4'd9, 128'd1 << 127);
    lookup_key(64'hFFFF_FFFF_FFFF_FFFE);

    while (issued < ITEM_TOTAL) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          issue(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                {rand64(), rand64()}, rand64());
        end
      end else begin
        repeat ($urandom_range(0, 4)) begin
          load_seed(4'($urandom_range(0, 15)), seed_flavor());
        end
        repeat ($urandom_range(1, 2)) begin
          lookup_key(key_flavor());
        end
      end
    end
    start <= 1'b0;

    while (open_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
